>>> rtl/wtsp_pkg.sv
package wtsp_pkg;

  // port widths fixed by the item layout
  localparam int IO_W        = 32;
  localparam int IN_TDATA_W  = 7 * IO_W;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 2 * IO_W;
  localparam int CFG_W       = 15;

  // configuration register indexes
  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 15'd1920;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 15'd1080;

  // item kinds and matrix selectors
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;
  localparam logic MAT_VIEW   = 1'b0;
  localparam logic MAT_PROJ   = 1'b1;

  // step index of the clip term after the four combined-entry products
  localparam logic [2:0] K_CLIP = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_SAT_C,
    ST_SAT_P,
    ST_CHECK,
    ST_DIV,
    ST_SCR_MUL,
    ST_SCR_ACC,
    ST_OUT
  } seq_state_t;

  // element read address into the matrix store
  typedef struct packed {
    logic [1:0] row_i;  // view row
    logic [1:0] k;      // view column, projection row
    logic [1:0] col;    // projection column
  } mat_rd_t;

endpackage

>>> rtl/world_to_screen_projection.sv
// channel   dir  handshake                  payload
// s_*       in   s_tvalid / s_tready        s_tuser: op, matrix_select, row_index
//                                           s_tdata: elem0..elem3, pos_x, pos_y, pos_z
// m_*       out  m_tvalid / m_tready        m_tuser: visible; m_tdata: screen_x, screen_y
// cfg_*     in   cfg_we                     cfg_addr: register index, cfg_data: value
//
// a load word is taken in one cycle and gives no result
// a project word runs 60 products through the one shared multiplier, then, when clip w is
// positive, two restoring divides at one quotient bit a cycle and two viewport products;
// s_tready is low meanwhile
// the result sits in an output register, so the next word is taken while it waits
// synchronous reset clears both matrices and loads the default viewport size
module world_to_screen_projection #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // elem0, elem1, elem2, elem3, pos_x, pos_y, pos_z (32 bits each, from bit 0 up)
  input  logic [wtsp_pkg::IN_TDATA_W-1:0]  s_tdata,
  // op, matrix_select, row_index[1:0] (from bit 0 up)
  input  logic [wtsp_pkg::IN_TUSER_W-1:0]  s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // screen_x, screen_y (32 bits each, from bit 0 up)
  output logic [wtsp_pkg::OUT_TDATA_W-1:0] m_tdata,
  // visible
  output logic                             m_tuser,
  input  logic                             cfg_we,
  input  logic                             cfg_addr,
  input  logic [wtsp_pkg::CFG_W-1:0]       cfg_data
);
  import wtsp_pkg::*;

  localparam int VW    = VALUE_WIDTH;
  localparam int MW    = VW + 1;          // multiplier operand width
  localparam int ACC_W = 2 * MW;          // product and accumulator width
  localparam int NW    = VW + FRAC_BITS;  // dividend width
  localparam int EXT_W = (VW > IO_W) ? VW : IO_W;

  localparam logic signed [VW-1:0] VMAX    = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN    = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] ONE_RAW = {{(VW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [VW-1:0] ONE     = (FRAC_BITS >= VW - 1) ? VMAX : ONE_RAW;
  localparam logic [NW-1:0]        QPOS    = NW'({1'b0, {(VW-1){1'b1}}});
  localparam logic [NW-1:0]        QNEG    = NW'({1'b1, {(VW-1){1'b0}}});

  // port value to internal width, saturated when narrower
  function automatic logic signed [VW-1:0] in_val(input logic [IO_W-1:0] u);
    logic signed [EXT_W-1:0] e;
    e = EXT_W'(signed'(u));
    if (e > EXT_W'(VMAX)) return VMAX;
    if (e < EXT_W'(VMIN)) return VMIN;
    return VW'(e);
  endfunction

  function automatic logic [IO_W-1:0] out_val(input logic signed [VW-1:0] v);
    logic signed [EXT_W-1:0] e;
    e = EXT_W'(v);
    return e[IO_W-1:0];
  endfunction

  function automatic logic signed [VW-1:0] sat_w(input logic signed [ACC_W-1:0] x);
    if (x > ACC_W'(VMAX)) return VMAX;
    if (x < ACC_W'(VMIN)) return VMIN;
    return VW'(x);
  endfunction

  // drop the fraction of a product sum, then saturate
  function automatic logic signed [VW-1:0] sat_acc(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] s;
    s = x >>> FRAC_BITS;
    return sat_w(s);
  endfunction

  // signed quotient from magnitude, saturated
  function automatic logic signed [VW-1:0] q_sat(input logic [NW-1:0] q, input logic neg);
    logic [VW-1:0] t;
    t = VW'(q);
    if (neg) begin
      if (q > QNEG) return VMIN;
      return -t;
    end
    if (q > QPOS) return VMAX;
    return t;
  endfunction

  seq_state_t state, state_next;

  // viewport size
  logic [CFG_W-1:0] screen_width, screen_height;

  // loop counters
  logic [1:0] i, jc;
  logic [2:0] k;
  logic       dsel, ssel;

  // working values
  logic signed [VW-1:0]    pt [3];
  logic signed [VW-1:0]    comb_r;
  logic signed [ACC_W-1:0] acc_c, acc_p;
  logic signed [VW-1:0]    clip_x, clip_y, clip_w;
  logic signed [VW-1:0]    nx, ny, sx, sy;
  logic                    vis;

  // matrix store
  mat_rd_t                  rd;
  logic [3:0][VW-1:0]       wr_row;
  logic                     mat_we;
  logic [VW-1:0]            view_e, proj_e;

  // shared multiplier
  logic                     mul_en;
  logic signed [MW-1:0]     mul_a, mul_b;
  logic signed [ACC_W-1:0]  prod;

  // divider
  logic                     div_start, div_done;
  logic [NW-1:0]            div_num, div_quot;
  logic [VW-2:0]            div_den;
  logic [VW-1:0]            mag_x, mag_y;

  logic                     s_acc, is_project, w_pos, out_free;
  logic signed [VW-1:0]     pt_sel;
  logic signed [ACC_W-1:0]  rnd, half;

  assign s_tready   = (state == ST_IDLE);
  assign s_acc      = s_tvalid && s_tready;
  assign is_project = (s_tuser[0] == OP_PROJECT);
  assign out_free   = !m_tvalid || m_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // load words go straight into the store
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      wr_row[c] = in_val(s_tdata[c*IO_W +: IO_W]);
    end
  end
  assign mat_we = s_acc && (s_tuser[0] == OP_LOAD);

  // only columns 0, 1 and 3 of the combined matrix feed clip x, y and w
  assign rd.row_i = i;
  assign rd.k     = k[1:0];
  assign rd.col   = (jc == 2'd2) ? 2'd3 : jc;

  wtsp_mat #(
    .VALUE_WIDTH(VW)
  ) u_mat (
    .clk    (clk),
    .rst    (rst),
    .we     (mat_we),
    .sel    (s_tuser[1]),
    .row    (s_tuser[3:2]),
    .wr_row (wr_row),
    .rd     (rd),
    .view_e (view_e),
    .proj_e (proj_e)
  );

  // point component for the clip term, w is one
  assign pt_sel = (i == 2'd3) ? ONE : pt[i];

  // multiplier operand select
  always_comb begin
    if (state == ST_SCR_MUL) begin
      if (!ssel) begin
        mul_a = MW'(nx) + MW'(ONE);
        mul_b = MW'({1'b0, screen_width});
      end else begin
        mul_a = MW'(ONE) - MW'(ny);
        mul_b = MW'({1'b0, screen_height});
      end
    end else if (k == K_CLIP) begin
      mul_a = MW'(pt_sel);
      mul_b = MW'(comb_r);
    end else begin
      mul_a = MW'(signed'(view_e));
      mul_b = MW'(signed'(proj_e));
    end
  end

  wtsp_mult #(
    .OP_W(MW)
  ) u_mult (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // divide |clip| << frac by w; w is positive whenever a divide starts
  assign w_pos   = !clip_w[VW-1] && (clip_w != '0);
  assign mag_x   = clip_x[VW-1] ? VW'(-clip_x) : VW'(clip_x);
  assign mag_y   = clip_y[VW-1] ? VW'(-clip_y) : VW'(clip_y);
  assign div_num = (state == ST_DIV) ? {mag_y, {FRAC_BITS{1'b0}}}
                                     : {mag_x, {FRAC_BITS{1'b0}}};
  assign div_den = clip_w[VW-2:0];

  wtsp_div #(
    .NUM_W(NW),
    .DEN_W(VW - 1)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // halve with truncation toward zero
  assign rnd  = prod[ACC_W-1] ? ACC_W'(1) : '0;
  assign half = (prod + rnd) >>> 1;

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    mul_en     = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_acc && is_project) state_next = ST_MUL;
      end
      ST_MUL: begin
        mul_en     = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        if (k == K_CLIP) begin
          state_next = (i == 2'd3) ? ST_SAT_P : ST_MUL;
        end else if (k == 3'd3) begin
          state_next = ST_SAT_C;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_SAT_C: begin
        state_next = ST_MUL;
      end
      ST_SAT_P: begin
        state_next = (jc == 2'd2) ? ST_CHECK : ST_MUL;
      end
      ST_CHECK: begin
        if (w_pos) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (!dsel) begin
            div_start = 1'b1;
          end else begin
            state_next = ST_SCR_MUL;
          end
        end
      end
      ST_SCR_MUL: begin
        mul_en     = 1'b1;
        state_next = ST_SCR_ACC;
      end
      ST_SCR_ACC: begin
        state_next = ssel ? ST_OUT : ST_SCR_MUL;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      i    <= '0;
      k    <= '0;
      jc   <= '0;
      dsel <= 1'b0;
      ssel <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          i  <= '0;
          k  <= '0;
          jc <= '0;
        end
        ST_ACC: begin
          if (k == K_CLIP) begin
            k <= '0;
            if (i != 2'd3) i <= i + 2'd1;
          end else begin
            k <= k + 3'd1;
          end
        end
        ST_SAT_P: begin
          i  <= '0;
          jc <= jc + 2'd1;
        end
        ST_CHECK: begin
          dsel <= 1'b0;
          ssel <= 1'b0;
        end
        ST_DIV: begin
          if (div_done) dsel <= 1'b1;
        end
        ST_SCR_ACC: begin
          ssel <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_acc && is_project) begin
          for (int c = 0; c < 3; c++) begin
            pt[c] <= in_val(s_tdata[(4 + c)*IO_W +: IO_W]);
          end
        end
      end
      ST_ACC: begin
        if (k == K_CLIP) begin
          acc_p <= (i == 2'd0) ? prod : acc_p + prod;
        end else begin
          acc_c <= (k == 3'd0) ? prod : acc_c + prod;
        end
      end
      ST_SAT_C: begin
        comb_r <= sat_acc(acc_c);
      end
      ST_SAT_P: begin
        case (jc)
          2'd0:    clip_x <= sat_acc(acc_p);
          2'd1:    clip_y <= sat_acc(acc_p);
          default: clip_w <= sat_acc(acc_p);
        endcase
      end
      ST_CHECK: begin
        vis <= w_pos;
        sx  <= '0;
        sy  <= '0;
      end
      ST_DIV: begin
        if (div_done) begin
          if (!dsel) begin
            nx <= q_sat(div_quot, clip_x[VW-1]);
          end else begin
            ny <= q_sat(div_quot, clip_y[VW-1]);
          end
        end
      end
      ST_SCR_ACC: begin
        if (!ssel) begin
          sx <= sat_w(half);
        end else begin
          sy <= sat_w(half);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_tuser <= vis;
      m_tdata <= {out_val(sy), out_val(sx)};
    end
  end

endmodule

>>> rtl/wtsp_mat.sv
module wtsp_mat #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          we,
  input  logic                          sel,
  input  logic [1:0]                    row,
  input  logic [3:0][VALUE_WIDTH-1:0]   wr_row,
  input  wtsp_pkg::mat_rd_t             rd,
  output logic [VALUE_WIDTH-1:0]        view_e,
  output logic [VALUE_WIDTH-1:0]        proj_e
);
  import wtsp_pkg::*;

  logic [3:0][VALUE_WIDTH-1:0] view_m [4];
  logic [3:0][VALUE_WIDTH-1:0] proj_m [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 4; r++) begin
        view_m[r] <= '0;
        proj_m[r] <= '0;
      end
    end else if (we) begin
      if (sel == MAT_PROJ) begin
        proj_m[row] <= wr_row;
      end else begin
        view_m[row] <= wr_row;
      end
    end
  end

  assign view_e = view_m[rd.row_i][rd.k];
  assign proj_e = proj_m[rd.k][rd.col];

endmodule

>>> rtl/wtsp_mult.sv
module wtsp_mult #(
  parameter int OP_W = 33
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [OP_W-1:0]     a,
  input  logic signed [OP_W-1:0]     b,
  output logic signed [2*OP_W-1:0]   prod
);

  // registered signed product
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

>>> rtl/wtsp_div.sv
module wtsp_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic              done,
  output logic [NUM_W-1:0]  quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] numsh;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  // restoring step: one quotient bit a cycle, msb first
  assign trial = {rem, numsh[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      numsh <= num;
      den_r <= den;
      rem   <= '0;
      quot  <= '0;
    end else if (busy) begin
      numsh <= numsh << 1;
      rem   <= fits ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
      quot  <= {quot[NUM_W-2:0], fits};
    end
  end

endmodule
